// ----- rtl/ps2mt_pkg.sv -----
package ps2mt_pkg;

  localparam int unsigned PositionWidthDefault = 32;

  localparam int unsigned InTdataWidth  = 8;
  localparam int unsigned OutPosWidth   = 32;
  // status + pos_x + pos_y + three buttons, padded to whole bytes
  localparam int unsigned OutFieldBits  = 2 + 2 * OutPosWidth + 3;
  localparam int unsigned OutTdataWidth = ((OutFieldBits + 7) / 8) * 8;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_OVERFLOW   = 2'd1,
    STATUS_EXTRA_BITS = 2'd2
  } status_e;

  // Flag byte layout
  localparam int unsigned FlagLeft    = 0;
  localparam int unsigned FlagMiddle  = 2;
  localparam int unsigned FlagSync    = 3;
  localparam int unsigned FlagXSign   = 4;
  localparam int unsigned FlagYSign   = 5;

  typedef logic [1:0] byte_idx_t;

  localparam byte_idx_t IdxFirst  = 2'd0;
  localparam byte_idx_t IdxThird  = 2'd2;
  localparam byte_idx_t IdxFourth = 2'd3;

endpackage

// ----- rtl/ps2_mouse_packet_tracker.sv -----
// PS/2 mouse packet tracker.
// Bytes from the mouse enter on the s_axis channel (tdata = data_byte), one
// transfer per byte. Three bytes, or four when four_byte_packets is set
// through cfg_we_i/cfg_wdata_i, make a packet. A first byte with bit 3 clear
// is dropped to regain sync. Each completed packet yields one transfer on
// m_axis: a status code, the accumulated x and y positions (y grows downward)
// and the three latched buttons. Overflowed packets and four-byte packets
// with bit 6 or 7 of byte 4 set leave position and buttons unchanged.
// The result for a packet's last byte is registered and appears on m_axis in the
// cycle after that byte's transfer. One byte per cycle is taken while the output is
// not stalled; all work for a byte is one add per axis feeding the output register.
// s_axis_tready drops only while a result is held and m_axis_tready is low;
// a stalled result holds steady until taken.
// Reset clears the byte position, positions, buttons, the packet-length
// register and the output valid flag.
module ps2_mouse_packet_tracker
  import ps2mt_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = PositionWidthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,    // four_byte_packets
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [InTdataWidth-1:0]  s_axis_tdata,   // [7:0] data_byte
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [1:0] status, [33:2] pos_x, [65:34] pos_y, [66] left_button,
  // [67] right_button, [68] middle_button, rest zero
  output logic [OutTdataWidth-1:0] m_axis_tdata
);

  logic                      four_q;
  byte_idx_t                 idx_q, idx_d;
  logic [7:0]                pb_q [3];
  logic [POSITION_WIDTH-1:0] cur_x_q, cur_x_d;
  logic [POSITION_WIDTH-1:0] cur_y_q, cur_y_d;
  logic [2:0]                btn_q, btn_d;

  logic                      out_valid_q;
  status_e                   out_status_q, status_d;
  logic [OutPosWidth-1:0]    out_x_q, out_y_q;
  logic [2:0]                out_btn_q;

  logic                      s_xfer, drop, complete;
  logic [7:0]                byte_in, flags, dy_byte;
  logic [POSITION_WIDTH-1:0] dx, dy;
  logic signed [63:0]        x_ext, y_ext;

  assign byte_in       = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  assign drop     = (idx_q == IdxFirst) && !byte_in[FlagSync];
  assign complete = !drop && (four_q ? (idx_q == IdxFourth) : (idx_q >= IdxThird));

  assign flags   = pb_q[0];
  assign dy_byte = four_q ? pb_q[2] : byte_in;
  assign dx = POSITION_WIDTH'(signed'({flags[FlagXSign], pb_q[1]}));
  assign dy = POSITION_WIDTH'(signed'({flags[FlagYSign], dy_byte}));

  always_comb begin
    idx_d    = idx_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    btn_d    = btn_q;
    status_d = STATUS_OK;
    if (four_q && (byte_in[7:6] != 2'b00)) begin
      status_d = STATUS_EXTRA_BITS;
    end else if (flags[7:6] != 2'b00) begin
      status_d = STATUS_OVERFLOW;
    end
    if (!drop) begin
      idx_d = complete ? IdxFirst : idx_q + 2'd1;
    end
    if (complete && (status_d == STATUS_OK)) begin
      cur_x_d = cur_x_q + dx;
      cur_y_d = cur_y_q - dy;
      btn_d   = flags[FlagMiddle:FlagLeft];
    end
  end

  // Sign-extend or trim the positions to the output field width
  assign x_ext = 64'(signed'(cur_x_d));
  assign y_ext = 64'(signed'(cur_y_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_q  <= 1'b0;
      idx_q   <= IdxFirst;
      cur_x_q <= '0;
      cur_y_q <= '0;
      btn_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        four_q <= cfg_wdata_i;
      end
      if (s_xfer) begin
        idx_q   <= idx_d;
        cur_x_q <= cur_x_d;
        cur_y_q <= cur_y_d;
        btn_q   <= btn_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer && !drop && (idx_q != IdxFourth)) begin
      pb_q[idx_q] <= byte_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_xfer && complete) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer && complete) begin
      out_status_q <= status_d;
      out_x_q      <= x_ext[OutPosWidth-1:0];
      out_y_q      <= y_ext[OutPosWidth-1:0];
      out_btn_q    <= btn_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutTdataWidth - OutFieldBits)'(0), out_btn_q,
                          out_y_q, out_x_q, out_status_q};

endmodule

// ----- rtl/ps2mt_checker.sv -----
module ps2mt_checker
  import ps2mt_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OutTdataWidth-1:0] m_axis_tdata
);

  logic                   m_xfer;
  logic [OutPosWidth-1:0] last_x_q, last_y_q;
  logic [2:0]             last_btn_q;

  assign m_xfer = m_axis_tvalid && m_axis_tready;

  // Track the last delivered position and buttons
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q   <= '0;
      last_y_q   <= '0;
      last_btn_q <= '0;
    end else if (m_xfer) begin
      last_x_q   <= m_axis_tdata[2 +: OutPosWidth];
      last_y_q   <= m_axis_tdata[2 + OutPosWidth +: OutPosWidth];
      last_btn_q <= m_axis_tdata[2 + 2 * OutPosWidth +: 3];
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == STATUS_OK) ||
                      (m_axis_tdata[1:0] == STATUS_OVERFLOW) ||
                      (m_axis_tdata[1:0] == STATUS_EXTRA_BITS))
    else $error("undefined status code");

  a_drop_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer && (m_axis_tdata[1:0] != STATUS_OK) |->
      (m_axis_tdata[2 +: OutPosWidth] == last_x_q) &&
      (m_axis_tdata[2 + OutPosWidth +: OutPosWidth] == last_y_q) &&
      (m_axis_tdata[2 + 2 * OutPosWidth +: 3] == last_btn_q))
    else $error("dropped packet changed position or buttons");

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_ps2mt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench
  import ps2mt_pkg::*;
();

  localparam int unsigned PosXLsb    = 2;
  localparam int unsigned PosYLsb    = PosXLsb + OutPosWidth;
  localparam int unsigned ButtonLsb  = PosYLsb + OutPosWidth;
  localparam int unsigned RandomBytes = 1150;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned PrintLimit  = 100;

  localparam logic [7:0] OverflowMask   = 8'hC0;  // X and Y overflow flags
  localparam logic [7:0] ExtraBitsMask  = 8'hC0;  // must be clear in byte 4

  typedef enum logic {
    ROW_BYTE,
    ROW_MODE
  } row_kind_e;

  typedef struct packed {
    status_e                status;
    logic [OutPosWidth-1:0] pos_x;
    logic [OutPosWidth-1:0] pos_y;
    logic [2:0]             buttons;  // [0] left, [1] right, [2] middle
  } mouse_report_t;

  typedef struct packed {
    row_kind_e     kind;
    logic [7:0]    value;
    logic          typed;
    mouse_report_t report;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_wdata_i;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [InTdataWidth-1:0]  s_axis_tdata;   // [7:0] data_byte
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  // [1:0] status, [33:2] pos_x, [65:34] pos_y, [66] left_button,
  // [67] right_button, [68] middle_button, rest zero
  logic [OutTdataWidth-1:0] m_axis_tdata;

  ps2_mouse_packet_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Tracker model state
  logic                   four_byte_mode;
  byte_idx_t              next_pos;
  logic [7:0]             held_bytes [3];
  logic [OutPosWidth-1:0] cur_x;
  logic [OutPosWidth-1:0] cur_y;
  logic [2:0]             buttons;

  mouse_report_t expected_reports [$];
  stim_row_t     stim_rows [$];
  int unsigned   error_count;
  int unsigned   taken_count;
  int unsigned   cycle_count;
  bit            src_calm;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PrintLimit)
      $display("%0t: mismatch in %s: got %h, want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Advance the packet tracker by one byte; flag whether the byte was kept
  // and whether it closed a packet.
  task automatic track_byte(input logic [7:0] b, output bit taken, output bit done,
                            output mouse_report_t rep);
    byte_idx_t  last_pos;
    logic [7:0] flags;
    logic [7:0] dy_low;
    taken = 1'b0;
    done  = 1'b0;
    rep   = '0;
    last_pos = four_byte_mode ? IdxFourth : IdxThird;
    if (next_pos != IdxFirst || b[FlagSync]) begin
      taken = 1'b1;
      if (next_pos != IdxFourth) held_bytes[next_pos] = b;
      if (next_pos < last_pos) begin
        next_pos = next_pos + 1'b1;
      end else begin
        next_pos = IdxFirst;
        flags  = held_bytes[0];
        dy_low = four_byte_mode ? held_bytes[2] : b;
        if (four_byte_mode && (b & ExtraBitsMask) != 0) begin
          rep.status = STATUS_EXTRA_BITS;
        end else if ((flags & OverflowMask) != 0) begin
          rep.status = STATUS_OVERFLOW;
        end else begin
          rep.status = STATUS_OK;
          cur_x = cur_x + {{(OutPosWidth-8){flags[FlagXSign]}}, held_bytes[1]};
          cur_y = cur_y - {{(OutPosWidth-8){flags[FlagYSign]}}, dy_low};
          buttons = flags[FlagMiddle:FlagLeft];
        end
        rep.pos_x   = cur_x;
        rep.pos_y   = cur_y;
        rep.buttons = buttons;
        done = 1'b1;
      end
    end
  endtask

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input bit use_typed,
                           input mouse_report_t typed_rep);
    int unsigned   gap;
    bit            taken;
    bit            done;
    mouse_report_t rep;
    gap = (!src_calm && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    repeat (gap) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    track_byte(b, taken, done, rep);
    if (done) expected_reports.push_back(use_typed ? typed_rep : rep);
    if (taken) taken_count++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Hold off until every result is out and the block has settled, then write.
  task automatic write_mode(input logic mode);
    s_axis_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = mode;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    four_byte_mode = mode;
  endtask

  // Send the first n bytes of a random packet; n below the length breaks sync.
  task automatic send_packet(input int unsigned n);
    logic [7:0] pkt [4];
    for (int i = 0; i < 4; i++) pkt[i] = $urandom_range(0, 255);
    pkt[0][FlagSync] = 1'b1;
    if ($urandom_range(0, 5) != 0) pkt[0] = pkt[0] & ~OverflowMask;
    if ($urandom_range(0, 5) != 0) pkt[3] = pkt[3] & ~ExtraBitsMask;
    for (int i = 0; i < n; i++) send_byte(pkt[i], 1'b0, '0);
  endtask

  task automatic add_byte(input logic [7:0] b);
    stim_rows.push_back({ROW_BYTE, b, 1'b0, mouse_report_t'('0)});
  endtask

  task automatic add_checked(input logic [7:0] b, input status_e st,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [2:0] btn);
    stim_rows.push_back({ROW_BYTE, b, 1'b1, st, x, y, btn});
  endtask

  task automatic add_mode(input logic mode);
    stim_rows.push_back({ROW_MODE, {7'd0, mode}, 1'b0, mouse_report_t'('0)});
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin : check_results
    mouse_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_reports.pop_front();
        if (m_axis_tdata[1:0] != want.status)
          report_mismatch("status", 32'(m_axis_tdata[1:0]), 32'(want.status));
        if (m_axis_tdata[PosXLsb +: OutPosWidth] != want.pos_x)
          report_mismatch("pos_x", m_axis_tdata[PosXLsb +: OutPosWidth], want.pos_x);
        if (m_axis_tdata[PosYLsb +: OutPosWidth] != want.pos_y)
          report_mismatch("pos_y", m_axis_tdata[PosYLsb +: OutPosWidth], want.pos_y);
        if (m_axis_tdata[ButtonLsb] != want.buttons[0])
          report_mismatch("left_button", 32'(m_axis_tdata[ButtonLsb]),
                          32'(want.buttons[0]));
        if (m_axis_tdata[ButtonLsb+1] != want.buttons[1])
          report_mismatch("right_button", 32'(m_axis_tdata[ButtonLsb+1]),
                          32'(want.buttons[1]));
        if (m_axis_tdata[ButtonLsb+2] != want.buttons[2])
          report_mismatch("middle_button", 32'(m_axis_tdata[ButtonLsb+2]),
                          32'(want.buttons[2]));
      end
    end
  end

  // Result side: random stalls, with calm stretches that start no new stall
  initial begin : drive_sink
    int unsigned stall_left;
    int unsigned stretch_left;
    bit          calm;
    stall_left   = 0;
    stretch_left = 0;
    calm         = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stretch_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        stretch_left = $urandom_range(50, 300);
      end
      stretch_left--;
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) stall_left = idle_len();
      end
    end
  end

  initial begin : drive_source
    int unsigned phase_len;
    int unsigned phase_start;
    int unsigned pick;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    four_byte_mode = 1'b0;
    next_pos      = IdxFirst;
    for (int i = 0; i < 3; i++) held_bytes[i] = '0;
    cur_x         = '0;
    cur_y         = '0;
    buttons       = '0;
    error_count   = 0;
    taken_count   = 0;
    cycle_count   = 0;
    src_calm      = 1'b0;

    // Three-byte mode after reset: out-of-sync drops, zero and full negative
    // deltas, overflow keeps the position.
    add_byte(8'h00);
    add_byte(8'hF7);
    add_byte(8'h08); add_byte(8'h00);
    add_checked(8'h00, STATUS_OK, 32'h0000_0000, 32'h0000_0000, 3'b000);
    add_byte(8'h3F); add_byte(8'h00);
    add_checked(8'h00, STATUS_OK, 32'hFFFF_FF00, 32'h0000_0100, 3'b111);
    add_byte(8'hC8); add_byte(8'hFF);
    add_checked(8'hFF, STATUS_OVERFLOW, 32'hFFFF_FF00, 32'h0000_0100, 3'b111);
    // Four-byte mode: byte 4 check wins over overflow, then overflow alone,
    // then a clean packet with x delta 0x7F and y delta 0x80.
    add_mode(1'b1);
    add_byte(8'hC8); add_byte(8'h12); add_byte(8'h34);
    add_checked(8'h80, STATUS_EXTRA_BITS, 32'hFFFF_FF00, 32'h0000_0100, 3'b111);
    add_byte(8'h4A); add_byte(8'h01); add_byte(8'h02);
    add_checked(8'h00, STATUS_OVERFLOW, 32'hFFFF_FF00, 32'h0000_0100, 3'b111);
    add_byte(8'h0D); add_byte(8'h7F); add_byte(8'h80); add_byte(8'h3F);
    // Length drops to three with three bytes held: the next byte closes it
    add_byte(8'h08); add_byte(8'h05); add_byte(8'h06);
    add_mode(1'b0);
    add_byte(8'h07);

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_MODE)
        write_mode(stim_rows[i].value[0]);
      else
        send_byte(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].report);
    end

    taken_count = 0;
    while (taken_count < RandomBytes) begin
      write_mode(1'($urandom_range(0, 1)));
      src_calm    = ($urandom_range(0, 3) == 0);
      phase_len   = $urandom_range(20, 160);
      phase_start = taken_count;
      while ((taken_count - phase_start < phase_len) && (taken_count < RandomBytes)) begin
        pick = $urandom_range(0, 99);
        if (pick < 82)
          send_packet(four_byte_mode ? 4 : 3);
        else if (pick < 91)
          send_packet($urandom_range(1, four_byte_mode ? 3 : 2));
        else
          send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    s_axis_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
